FILE: rtl/upd_pkg.sv
// Shared types and helpers for the URL percent decoder.
// Holds the command record passed from the classifier to the emitter.
// No dependencies.
package upd_pkg;

  localparam int unsigned CmdqDepth = 4;

  localparam logic [7:0] PctChar = 8'h25;

  // One classified input byte: up to three result bytes, oldest in chars[0]
  typedef struct packed {
    logic [1:0]      cnt;
    logic            fin;
    logic [2:0][7:0] chars;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Nibble value of a hex digit of either case
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h61) begin
      v = c - 8'h57;
    end else if (c >= 8'h41) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h30;
    end
    hex_value = v[3:0];
  endfunction

endpackage

FILE: rtl/upd_front.sv
// Front end of the URL percent decoder: tracks the escape phase and turns
// each input byte into a command of zero to three result bytes.
// Depends on upd_pkg.
module upd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic [7:0]    in_char,
  input  logic          in_final,
  input  logic          q_full,
  output logic          in_full,
  output logic          q_wr_en,
  output upd_pkg::cmd_t q_wr_cmd
);
  import upd_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       accept;
  logic       c_hex;
  logic       c_opens;
  cmd_t       cmd;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign c_hex   = is_hex(in_char);
  // A '%' opens an escape unless it is the last byte
  assign c_opens = (in_char == PctChar) && !in_final;

  // Classify the byte against the current phase
  always_comb begin
    phase_nxt = PH_IDLE;
    held_nxt  = held_r;
    cmd.cnt   = 2'd0;
    cmd.fin   = in_final;
    cmd.chars = {8'h00, 8'h00, 8'h00};
    unique case (phase_r)
      PH_PCT: begin
        if (c_hex && !in_final) begin
          held_nxt  = in_char;
          phase_nxt = PH_DIGIT;
        end else if (c_hex || !c_opens) begin
          cmd.cnt      = 2'd2;
          cmd.chars[0] = PctChar;
          cmd.chars[1] = in_char;
        end else begin
          cmd.cnt      = 2'd1;
          cmd.chars[0] = PctChar;
          phase_nxt    = PH_PCT;
        end
      end
      PH_DIGIT: begin
        cmd.chars[0] = PctChar;
        cmd.chars[1] = held_r;
        if (c_hex) begin
          cmd.cnt      = 2'd1;
          cmd.chars[0] = {hex_value(held_r), hex_value(in_char)};
        end else if (c_opens) begin
          cmd.cnt   = 2'd2;
          phase_nxt = PH_PCT;
        end else begin
          cmd.cnt      = 2'd3;
          cmd.chars[2] = in_char;
        end
      end
      default: begin
        if (c_opens) begin
          phase_nxt = PH_PCT;
        end else begin
          cmd.cnt      = 2'd1;
          cmd.chars[0] = in_char;
        end
      end
    endcase
  end

  assign q_wr_en  = accept && (cmd.cnt != 2'd0);
  assign q_wr_cmd = cmd;

  // Advance the phase on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

FILE: rtl/upd_cmdq.sv
// Command queue between the decoder front end and the result emitter.
// Small flip-flop FIFO with a registered fill count; depends on upd_pkg.
module upd_cmdq #(
  parameter int unsigned DEPTH = upd_pkg::CmdqDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  upd_pkg::cmd_t wr_cmd,
  input  logic          rd_en,
  output upd_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);
  import upd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = slots_r[rd_ptr_r];

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/upd_back.sv
// Back end of the URL percent decoder: walks each queued command one byte
// per cycle into the output register while that register is free or being popped. Depends on upd_pkg.
module upd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  upd_pkg::cmd_t q_rd_cmd,
  input  logic          q_empty,
  output logic          q_rd_en,
  input  logic          out_pop,
  output logic          out_empty,
  output logic [7:0]    out_char,
  output logic          out_final
);
  import upd_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_final_r;
  logic       load;
  logic       last;

  // Load when the output register is free or being drained
  assign load    = !q_empty && (!out_valid_r || out_pop);
  assign last    = (idx_r == q_rd_cmd.cnt - 2'd1);
  assign q_rd_en = load && last;

  assign out_empty = !out_valid_r;
  assign out_char  = out_char_r;
  assign out_final = out_final_r;

  // Hold the output transaction until popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last ? 2'd0 : idx_r + 2'd1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r  <= q_rd_cmd.chars[idx_r];
      out_final_r <= q_rd_cmd.fin && last;
    end
  end

endmodule

FILE: rtl/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
// Instantiates upd_front, upd_cmdq and upd_back; depends on upd_pkg.
//
// Usage:
//   Input channel: drive in_char / in_final and raise in_push; a byte is
//   taken at a clock edge where in_push is high and in_full is low. Set
//   in_final on the last byte of each string.
//   Result channel: while out_empty is low, out_char / out_final hold the
//   oldest result; raise out_pop to take it. out_final marks the last
//   result of a string.
//   A "%XY" escape with two hex digits becomes one byte; a broken escape
//   comes out as its literal bytes, so one input byte yields zero to three
//   results.
//   Path: the command for an accepted byte is written to the queue at the
//   accepting edge, then loaded from the queue into the output register,
//   where its results show one at a time.
//   Throughput: one byte per cycle while each byte yields at most one
//   result and the receiver pops every result; the emitter sends one result
//   per cycle while the output register is drained, so a byte yielding
//   three results holds it longer, absorbed by the command queue of CMDQ_DEPTH entries.
//   When the receiver stalls, the output register holds and the queue fills;
//   in_full rises once it is full. Reset clears the escape phase, the queue
//   and the output register; nothing is lost or repeated across a stall.
module url_percent_decoder #(
  parameter int unsigned CMDQ_DEPTH = upd_pkg::CmdqDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char,
  input  logic       in_final,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_final
);
  import upd_pkg::*;

  logic q_wr_en;
  cmd_t q_wr_cmd;
  logic q_rd_en;
  cmd_t q_rd_cmd;
  logic q_full;
  logic q_empty;

  // Classify input bytes
  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_char  (in_char),
    .in_final (in_final),
    .q_full   (q_full),
    .in_full  (in_full),
    .q_wr_en  (q_wr_en),
    .q_wr_cmd (q_wr_cmd)
  );

  // Decouple classification from emission
  upd_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr_en),
    .wr_cmd (q_wr_cmd),
    .rd_en  (q_rd_en),
    .rd_cmd (q_rd_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Emit result bytes
  upd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd_cmd  (q_rd_cmd),
    .q_empty   (q_empty),
    .q_rd_en   (q_rd_en),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_char  (out_char),
    .out_final (out_final)
  );

endmodule

FILE: bench/url_percent_decoder_tb.sv
// Self-checking bench for url_percent_decoder: random and directed strings,
// decoded by a local model and compared result by result at the output.
// Depends on upd_pkg and the url_percent_decoder RTL.
module url_percent_decoder_tb;
  import upd_pkg::*;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_PERCENT,
    ESC_DIGIT
  } esc_phase_t;

  // One byte with its end-of-string mark, used on both sides
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } str_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_char;
  logic       in_final;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_char;
  logic       out_final;

  str_byte_t  encoded_q[$];
  str_byte_t  decoded_q[$];
  str_byte_t  want;
  esc_phase_t esc_phase;
  logic [7:0] held_hex;
  int         send_idle_pct;
  int         pop_stall_pct;
  int         mismatch_count;

  url_percent_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_char  (in_char),
    .in_final (in_final),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_char (out_char),
    .out_final(out_final)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic bit is_hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // Low nibble of the ASCII code carries the value; letters sit nine above
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c <= "9") begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    int v;
    v = $urandom_range(15);
    if (v < 10) begin
      return 8'("0" + v);
    end
    return ($urandom_range(1) != 0) ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (is_hex_digit(c));
    return c;
  endfunction

  task automatic expect_byte(input logic [7:0] c, input logic fin);
    decoded_q.push_back('{ch: c, fin: fin});
  endtask

  // A byte seen with no escape open: start one or pass it through
  task automatic take_plain(input logic [7:0] c, input logic fin);
    if (c == PctChar && !fin) begin
      esc_phase = ESC_PERCENT;
    end else begin
      expect_byte(c, fin);
      esc_phase = ESC_IDLE;
    end
  endtask

  // Advance the decoder model by one accepted byte
  task automatic predict_decode(input logic [7:0] c, input logic fin);
    case (esc_phase)
      ESC_PERCENT: begin
        if (!is_hex_digit(c)) begin
          expect_byte(PctChar, 1'b0);
          take_plain(c, fin);
        end else if (fin) begin
          expect_byte(PctChar, 1'b0);
          expect_byte(c, 1'b1);
          esc_phase = ESC_IDLE;
        end else begin
          held_hex  = c;
          esc_phase = ESC_DIGIT;
        end
      end
      ESC_DIGIT: begin
        if (is_hex_digit(c)) begin
          expect_byte({digit_value(held_hex), digit_value(c)}, fin);
          esc_phase = ESC_IDLE;
        end else begin
          expect_byte(PctChar, 1'b0);
          expect_byte(held_hex, 1'b0);
          take_plain(c, fin);
        end
      end
      default: begin
        take_plain(c, fin);
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] c, input logic fin);
    encoded_q.push_back('{ch: c, fin: fin});
  endtask

  // Queue one string of random tokens, mostly well-formed escapes and text
  task automatic queue_string(inout int count);
    logic [7:0] body[$];
    int         tokens;
    int         pick;
    int         i;
    tokens = $urandom_range(8, 1);
    for (i = 0; i < tokens; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        body.push_back(8'($urandom_range(255)));
      end else if (pick < 70) begin
        body.push_back(PctChar);
        body.push_back(rand_hex_digit());
        body.push_back(rand_hex_digit());
      end else if (pick < 85) begin
        body.push_back(PctChar);
        if ($urandom_range(1) != 0) begin
          body.push_back(rand_hex_digit());
        end
        body.push_back(($urandom_range(3) == 0) ? PctChar : rand_non_hex());
      end else if (pick < 93) begin
        body.push_back(PctChar);
      end else begin
        repeat ($urandom_range(4, 1)) body.push_back(8'($urandom_range(255)));
      end
    end
    // Cut the string short now and then so the final byte lands mid-escape
    if ($urandom_range(4) == 0 && body.size() > 1) begin
      body = body[0:$urandom_range(body.size() - 1)];
    end
    for (i = 0; i < body.size(); i++) begin
      send_byte(body[i], i == body.size() - 1);
    end
    count += body.size();
  endtask

  task automatic drain_all();
    while (encoded_q.size() != 0 || decoded_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: hold a transaction while full, otherwise offer the next byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push   <= 1'b0;
      in_char   <= 8'h00;
      in_final  <= 1'b0;
      esc_phase = ESC_IDLE;
      held_hex  = 8'h00;
    end else begin
      if (in_push && !in_full) begin
        predict_decode(in_char, in_final);
        void'(encoded_q.pop_front());
      end
      if (in_push && in_full) begin
        in_push <= 1'b1;
      end else if (encoded_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_push  <= 1'b1;
        in_char  <= encoded_q[0].ch;
        in_final <= encoded_q[0].fin;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor: check each popped result against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result char %02h final %0b",
                                    out_char, out_final));
        end else begin
          want = decoded_q.pop_front();
          if (out_char !== want.ch) begin
            report_mismatch($sformatf("out_char %02h, want %02h", out_char, want.ch));
          end
          if (out_final !== want.fin) begin
            report_mismatch($sformatf("out_final %0b, want %0b on char %02h",
                                      out_final, want.fin, want.ch));
          end
        end
      end
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  initial begin
    #(20 * 200000);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int ph;
    int queued;
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    pop_stall_pct  = 0;
    mismatch_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes and zero byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Valid escapes, one ending the string
    send_byte(PctChar, 1'b0); send_byte("4", 1'b0); send_byte("1", 1'b0);
    send_byte(PctChar, 1'b0); send_byte("f", 1'b0); send_byte("F", 1'b1);
    // Final byte right after the percent sign
    send_byte(PctChar, 1'b0); send_byte("G", 1'b1);
    // Broken escape whose third byte opens a new escape
    send_byte(PctChar, 1'b0); send_byte("a", 1'b0); send_byte(PctChar, 1'b0);
    send_byte("2", 1'b0); send_byte("0", 1'b0);
    // Final hex digit with the escape half open
    send_byte(PctChar, 1'b0); send_byte("9", 1'b1);
    // Broken after one digit on the final byte: three results
    send_byte(PctChar, 1'b0); send_byte("B", 1'b0); send_byte("x", 1'b1);
    // Percent sign as the final byte, alone and after another
    send_byte(PctChar, 1'b1);
    send_byte(PctChar, 1'b0); send_byte(PctChar, 1'b1);
    // Sender holds off here until every result has come back
    drain_all();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 47; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 47; end
        default: begin send_idle_pct = 7; pop_stall_pct = 7; end
      endcase
      queued = 0;
      while (queued < 105) begin
        if ($urandom_range(19) == 0) begin
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
          queued++;
        end else begin
          queue_string(queued);
        end
      end
      drain_all();
    end

    repeat (10) @(posedge clk);
    if (decoded_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
